FILE: sv/stm_pkg.sv
// Shared types and constants for the stick-to-servo mapper.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package stm_pkg;

  // Sample width default (allowed range 8..16)
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Throttle divider yields an 8-bit quotient (at most 180)
  localparam int unsigned QUOT_BITS   = 8;
  // Stage 1 clamp/offset, stage 2 multiply, then one stage per quotient bit
  localparam int unsigned PIPE_STAGES = 2 + QUOT_BITS;

  localparam int unsigned CMD_BITS = 8;

  // Register reset values before truncation to the sample width
  localparam int unsigned CENTER_RESET    = 2048;
  localparam int unsigned THR_LOW_RESET   = 0;
  localparam int unsigned THR_HIGH_RESET  = 4095;
  localparam int unsigned DEAD_BAND_RESET = 100;

  // Servo command limits
  localparam logic [CMD_BITS-1:0] AXIS_MIN  = 8'd45;
  localparam logic [CMD_BITS-1:0] AXIS_MAX  = 8'd135;
  localparam logic [CMD_BITS-1:0] AXIS_SPAN = 8'd90;
  localparam logic [CMD_BITS-1:0] THR_MIN   = 8'd0;
  localparam logic [CMD_BITS-1:0] THR_MAX   = 8'd180;

  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROLL_CENTER   = 3'd0,
    CFG_PITCH_CENTER  = 3'd1,
    CFG_YAW_CENTER    = 3'd2,
    CFG_THROTTLE_LOW  = 3'd3,
    CFG_THROTTLE_HIGH = 3'd4,
    CFG_DEAD_BAND     = 3'd5
  } cfg_reg_e;

  // How the throttle lane forms its command
  typedef enum logic [1:0] {
    THR_ZERO = 2'd0,
    THR_FULL = 2'd1,
    THR_DIV  = 2'd2
  } thr_mode_e;

  // Per-stage load enables; en[k] loads stage k+1
  typedef struct packed {
    logic [PIPE_STAGES-1:0] en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: sv/stm_sample_if.sv
// Request channel carrying one set of four stick samples.
// Depends on stm_pkg for the default sample width.
`default_nettype none

interface stm_sample_if #(
  parameter int unsigned SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_horizontal;
  logic [SAMPLE_BITS-1:0] left_vertical;
  logic [SAMPLE_BITS-1:0] right_horizontal;
  logic [SAMPLE_BITS-1:0] right_vertical;

  modport source (
    output valid, left_horizontal, left_vertical, right_horizontal, right_vertical,
    input  ready
  );
  modport sink (
    input  valid, left_horizontal, left_vertical, right_horizontal, right_vertical,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/stm_cmd_if.sv
// Result channel carrying the four servo commands.
// Depends on stm_pkg for the command width.
`default_nettype none

interface stm_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [stm_pkg::CMD_BITS-1:0] throttle_cmd;
  logic [stm_pkg::CMD_BITS-1:0] roll_cmd;
  logic [stm_pkg::CMD_BITS-1:0] pitch_cmd;
  logic [stm_pkg::CMD_BITS-1:0] yaw_cmd;

  modport source (
    output valid, throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd,
    input  ready
  );
  modport sink (
    input  valid, throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/stm_center_lane.sv
// Centered-axis lane: offset, dead band, scale to 45..135, then delay to
// line up with the throttle lane. Depends on stm_pkg.
`default_nettype none

module stm_center_lane #(
  parameter int unsigned SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire stm_pkg::pipe_ctl_t      ctl_i,
  input  wire [SAMPLE_BITS-1:0]        pos_i,       // offset = pos - neg
  input  wire [SAMPLE_BITS-1:0]        neg_i,
  input  wire [SAMPLE_BITS-1:0]        dead_band_i,
  output logic [stm_pkg::CMD_BITS-1:0] cmd_o
);
  import stm_pkg::*;

  localparam int unsigned S     = SAMPLE_BITS;
  localparam int unsigned Half  = 1 << (S - 1);
  localparam int unsigned Mask  = (1 << S) - 1;
  localparam logic signed [S+8:0] Ninety = (S+9)'(90);

  // stage 1: signed offset after dead band
  logic signed [S:0]   off_raw;
  logic signed [S:0]   off_neg;
  logic [S-1:0]        mag;
  logic signed [S:0]   off_d, off_q;
  // stage 2: (off + half) * 90
  logic signed [S+1:0] biased;
  logic signed [S+8:0] biased_ext;
  logic signed [S+8:0] prod_d, prod_q;
  // stage 3: truncating divide by 2^S and clamp
  logic [S+8:0]        rounded;
  logic [8:0]          quo;
  logic [CMD_BITS-1:0] cmd_d;
  logic [CMD_BITS-1:0] cmd_q [3:PIPE_STAGES];

  always_comb begin
    off_raw = $signed({1'b0, pos_i}) - $signed({1'b0, neg_i});
    off_neg = -off_raw;
    mag     = off_raw[S] ? off_neg[S-1:0] : off_raw[S-1:0];
    off_d   = (mag < dead_band_i) ? '0 : off_raw;
  end

  always_comb begin
    biased     = {off_q[S], off_q} + (S+2)'(Half);
    biased_ext = {{7{biased[S+1]}}, biased};
    prod_d     = biased_ext * Ninety;
  end

  always_comb begin
    // negative values get a bias so the shift truncates toward zero
    rounded = prod_q + (prod_q[S+8] ? (S+9)'(Mask) : '0);
    quo     = rounded[S+8:S];
    if (quo[8]) begin
      cmd_d = AXIS_MIN;
    end else if (quo[7:0] > AXIS_SPAN) begin
      cmd_d = AXIS_MAX;
    end else begin
      cmd_d = quo[7:0] + AXIS_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) off_q <= off_d;
    if (ctl_i.en[1]) prod_q <= prod_d;
    if (ctl_i.en[2]) cmd_q[3] <= cmd_d;
    for (int k = 4; k <= PIPE_STAGES; k++) begin
      if (ctl_i.en[k-1]) cmd_q[k] <= cmd_q[k-1];
    end
  end

  assign cmd_o = cmd_q[PIPE_STAGES];

endmodule

`default_nettype wire

FILE: sv/stm_throttle_lane.sv
// Throttle lane: clamp to the calibration window, scale by 180, then a
// pipelined restoring divider, one quotient bit per stage; the command is 180 minus the quotient. Depends on stm_pkg.
`default_nettype none

module stm_throttle_lane #(
  parameter int unsigned SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire stm_pkg::pipe_ctl_t      ctl_i,
  input  wire [SAMPLE_BITS-1:0]        sample_i,
  input  wire [SAMPLE_BITS-1:0]        low_i,
  input  wire [SAMPLE_BITS-1:0]        high_i,
  output logic [stm_pkg::CMD_BITS-1:0] cmd_o
);
  import stm_pkg::*;

  localparam int unsigned S = SAMPLE_BITS;
  localparam int unsigned W = S + 8;   // holds diff * 180

  // stage 1
  thr_mode_e           mode_d;
  logic [S-1:0]        clamped;
  logic [S-1:0]        diff_d;
  logic [S-1:0]        span_d;
  thr_mode_e           mode1_q;
  logic [S-1:0]        diff1_q;
  logic [S-1:0]        span1_q;
  // stages 2..PIPE_STAGES
  thr_mode_e           mode_q [2:PIPE_STAGES];
  logic [S-1:0]        span_q [2:PIPE_STAGES];
  logic [W-1:0]        rem_q  [2:PIPE_STAGES];
  logic [QUOT_BITS-1:0] quo_q [2:PIPE_STAGES];
  logic [W-1:0]        trial  [QUOT_BITS];
  logic [QUOT_BITS-1:0] fits;

  always_comb begin
    if (sample_i < low_i) begin
      clamped = low_i;
    end else if (sample_i > high_i) begin
      clamped = high_i;
    end else begin
      clamped = sample_i;
    end
    diff_d = clamped - low_i;
    span_d = high_i - low_i;
    // reversed window: the clamp lands on one of the bounds, 180 or 0
    priority if (low_i == high_i) begin
      mode_d = THR_ZERO;
    end else if (low_i > high_i) begin
      mode_d = (sample_i < low_i) ? THR_FULL : THR_ZERO;
    end else begin
      mode_d = THR_DIV;
    end
  end

  // quotient never exceeds 180, so eight shifted trials cover it
  always_comb begin
    for (int j = 0; j < QUOT_BITS; j++) begin
      trial[j] = W'(span_q[2+j]) << (QUOT_BITS - 1 - j);
      fits[j]  = rem_q[2+j] >= trial[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      mode1_q <= mode_d;
      diff1_q <= diff_d;
      span1_q <= span_d;
    end
    if (ctl_i.en[1]) begin
      mode_q[2] <= mode1_q;
      span_q[2] <= span1_q;
      rem_q[2]  <= W'(diff1_q) * W'(THR_MAX);
      quo_q[2]  <= '0;
    end
    for (int j = 0; j < QUOT_BITS; j++) begin
      if (ctl_i.en[2+j]) begin
        mode_q[3+j] <= mode_q[2+j];
        span_q[3+j] <= span_q[2+j];
        rem_q[3+j]  <= fits[j] ? rem_q[2+j] - trial[j] : rem_q[2+j];
        quo_q[3+j]  <= quo_q[2+j] | (QUOT_BITS'(fits[j]) << (QUOT_BITS - 1 - j));
      end
    end
  end

  always_comb begin
    unique case (mode_q[PIPE_STAGES])
      THR_ZERO: cmd_o = THR_MIN;
      THR_FULL: cmd_o = THR_MAX;
      THR_DIV:  cmd_o = THR_MAX - quo_q[PIPE_STAGES];
      default:  cmd_o = THR_MIN;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/stick_to_servo_mapper_unit.sv
// Stick-to-servo mapper top level: configuration registers, pipeline flow
// control, four lanes and the merging output register.
// Depends on stm_pkg, stm_sample_if, stm_cmd_if, stm_center_lane, stm_throttle_lane.
//
// Usage:
//   sample_i takes one request of four stick samples when valid and ready are
//   both high; cmd_o presents the four servo commands with the same handshake.
//   Each request yields exactly one result, in order.
//   From acceptance to cmd_o.valid a request passes through ten lane
//   stages (clamp/offset, multiply, eight divider steps of the throttle
//   quotient) and the output register. Throughput is one request per cycle
//   while cmd_o.ready is high. Every stage holds only when its successor is
//   full and stalled, so empty stages keep filling and sample_i.ready stays
//   high while a result waits unless all eleven stages are occupied.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 roll center, 1 pitch center, 2 yaw center, 3 throttle low,
//   4 throttle high, 5 dead band); other indexes are ignored. Write only when
//   the pipeline is empty.
//   Reset clears all valid flags and loads the calibration defaults.
`default_nettype none

module stick_to_servo_mapper_unit #(
  parameter int unsigned SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  stm_sample_if.sink                      sample_i,
  stm_cmd_if.source                       cmd_o,
  input  wire                             cfg_we_i,
  input  wire [stm_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire [SAMPLE_BITS-1:0]           cfg_data_i
);
  import stm_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] CenterRst   = SAMPLE_BITS'(CENTER_RESET);
  localparam logic [SAMPLE_BITS-1:0] ThrLowRst   = SAMPLE_BITS'(THR_LOW_RESET);
  localparam logic [SAMPLE_BITS-1:0] ThrHighRst  = SAMPLE_BITS'(THR_HIGH_RESET);
  localparam logic [SAMPLE_BITS-1:0] DeadBandRst = SAMPLE_BITS'(DEAD_BAND_RESET);

  logic [SAMPLE_BITS-1:0] roll_center_q, pitch_center_q, yaw_center_q;
  logic [SAMPLE_BITS-1:0] thr_low_q, thr_high_q, dead_band_q;

  pipe_ctl_t              ctl;
  logic                   en_out;
  logic [PIPE_STAGES:1]   vld_q;
  logic                   out_valid_q;
  logic [CMD_BITS-1:0]    thr_cmd, roll_cmd, pitch_cmd, yaw_cmd;
  logic [CMD_BITS-1:0]    thr_cmd_q, roll_cmd_q, pitch_cmd_q, yaw_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_center_q  <= CenterRst;
      pitch_center_q <= CenterRst;
      yaw_center_q   <= CenterRst;
      thr_low_q      <= ThrLowRst;
      thr_high_q     <= ThrHighRst;
      dead_band_q    <= DeadBandRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROLL_CENTER:   roll_center_q  <= cfg_data_i;
        CFG_PITCH_CENTER:  pitch_center_q <= cfg_data_i;
        CFG_YAW_CENTER:    yaw_center_q   <= cfg_data_i;
        CFG_THROTTLE_LOW:  thr_low_q      <= cfg_data_i;
        CFG_THROTTLE_HIGH: thr_high_q     <= cfg_data_i;
        CFG_DEAD_BAND:     dead_band_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on this cycle
  always_comb begin
    en_out = !out_valid_q || cmd_o.ready;
    ctl.en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES] || en_out;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      ctl.en[k] = !vld_q[k+1] || ctl.en[k+1];
    end
  end

  assign sample_i.ready = ctl.en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl.en[0]) vld_q[1] <= sample_i.valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (ctl.en[k]) vld_q[k+1] <= vld_q[k];
      end
      if (en_out) out_valid_q <= vld_q[PIPE_STAGES];
    end
  end

  stm_throttle_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_throttle (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .sample_i (sample_i.right_vertical),
    .low_i    (thr_low_q),
    .high_i   (thr_high_q),
    .cmd_o    (thr_cmd)
  );

  stm_center_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_roll (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .pos_i       (sample_i.left_horizontal),
    .neg_i       (roll_center_q),
    .dead_band_i (dead_band_q),
    .cmd_o       (roll_cmd)
  );

  // pitch is inverted: offset taken as center minus sample
  stm_center_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_pitch (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .pos_i       (pitch_center_q),
    .neg_i       (sample_i.left_vertical),
    .dead_band_i (dead_band_q),
    .cmd_o       (pitch_cmd)
  );

  stm_center_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_yaw (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .pos_i       (sample_i.right_horizontal),
    .neg_i       (yaw_center_q),
    .dead_band_i (dead_band_q),
    .cmd_o       (yaw_cmd)
  );

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      thr_cmd_q   <= thr_cmd;
      roll_cmd_q  <= roll_cmd;
      pitch_cmd_q <= pitch_cmd;
      yaw_cmd_q   <= yaw_cmd;
    end
  end

  assign cmd_o.valid        = out_valid_q;
  assign cmd_o.throttle_cmd = thr_cmd_q;
  assign cmd_o.roll_cmd     = roll_cmd_q;
  assign cmd_o.pitch_cmd    = pitch_cmd_q;
  assign cmd_o.yaw_cmd      = yaw_cmd_q;

endmodule

`default_nettype wire
